[hdl/rmj_pkg.sv]
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared widths, transaction types and helpers for the radar Jacobian block.
// ----------------------------------------------------------------------------
package rmj_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // range squared, cross term
    localparam int SQ_W     = 2 * DATA_WIDTH;
    // range squared times range, and position times cross term
    localparam int PROD_W   = 3 * DATA_WIDTH;
    // square root partial remainder
    localparam int SQ_REM_W = DATA_WIDTH + 3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] vel_x;
        logic signed [DATA_WIDTH-1:0] vel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] range_dx;
        logic signed [DATA_WIDTH-1:0] range_dy;
        logic signed [DATA_WIDTH-1:0] bearing_dx;
        logic signed [DATA_WIDTH-1:0] bearing_dy;
        logic signed [DATA_WIDTH-1:0] rate_dx;
        logic signed [DATA_WIDTH-1:0] rate_dy;
        logic                         zero_range;
    } t_out_item;

    // magnitude of a two's complement value; the most negative value maps
    // to its unsigned magnitude
    function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
        mag_of = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

[hdl/rmj_isqrt.sv]
// ----------------------------------------------------------------------------
// rmj_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module rmj_isqrt
    import rmj_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [SQ_W-1:0]       i_sq,
    output logic [DATA_WIDTH-1:0] o_root
);

    typedef struct packed {
        logic [SQ_REM_W-1:0]   rem;
        logic [DATA_WIDTH-1:0] root;
        logic [SQ_W-1:0]       sq;
    } t_sq_stage;

    t_sq_stage r_st [DATA_WIDTH];
    t_sq_stage n_st [DATA_WIDTH];

    always_comb begin
        t_sq_stage           cur;
        logic [SQ_REM_W-1:0] sh;
        logic [SQ_REM_W-1:0] trial;
        for (int k = 0; k < DATA_WIDTH; k++) begin
            if (k == 0) begin
                cur = '{rem: '0, root: '0, sq: i_sq};
            end else begin
                cur = r_st[k-1];
            end
            // bring down the next two bits of the radicand
            sh    = {cur.rem[SQ_REM_W-3:0], cur.sq[SQ_W-1 -: 2]};
            trial = SQ_REM_W'({cur.root, 2'b01});
            n_st[k].sq = cur.sq << 2;
            if (sh >= trial) begin
                n_st[k].rem  = sh - trial;
                n_st[k].root = {cur.root[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_st[k].rem  = sh;
                n_st[k].root = {cur.root[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DATA_WIDTH; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = r_st[DATA_WIDTH-1].root;

endmodule

[hdl/rmj_div.sv]
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation of the truncated quotient.
// ----------------------------------------------------------------------------
module rmj_div
    import rmj_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [PROD_W-1:0]     i_hi,    // numerator above the quotient bits
    input  logic [DATA_WIDTH-1:0] i_lo,    // numerator bits that form the quotient
    input  logic [PROD_W-1:0]     i_den,
    input  logic                  i_neg,
    output logic [DATA_WIDTH-1:0] o_q
);

    typedef struct packed {
        logic [PROD_W-1:0]     rem;
        logic [DATA_WIDTH-1:0] lo;
        logic [PROD_W-1:0]     den;
        logic [DATA_WIDTH-1:0] q;
        logic                  ovf;
        logic                  neg;
    } t_div_stage;

    t_div_stage r_st [DATA_WIDTH+1];
    t_div_stage n_st [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] n_q;

    always_comb begin
        logic [PROD_W:0] sh;
        logic            ge;
        // quotient reaches 2^DATA_WIDTH when the high part is not below den
        n_st[0] = '{rem: i_hi, lo: i_lo, den: i_den, q: '0,
                    ovf: (i_hi >= i_den), neg: i_neg};
        for (int k = 1; k <= DATA_WIDTH; k++) begin
            sh = {r_st[k-1].rem, r_st[k-1].lo[DATA_WIDTH-1]};
            ge = (sh >= {1'b0, r_st[k-1].den});
            n_st[k]     = r_st[k-1];
            n_st[k].lo  = r_st[k-1].lo << 1;
            n_st[k].q   = {r_st[k-1].q[DATA_WIDTH-2:0], ge};
            n_st[k].rem = ge ? PROD_W'(sh - {1'b0, r_st[k-1].den}) : sh[PROD_W-1:0];
        end
    end

    always_comb begin
        logic [DATA_WIDTH-1:0] lim;
        logic [DATA_WIDTH-1:0] m;
        t_div_stage            fin;
        fin = r_st[DATA_WIDTH];
        lim = fin.neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        m   = (fin.ovf || fin.q > lim) ? lim : fin.q;
        n_q = fin.neg ? (~m + 1'b1) : m;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= DATA_WIDTH; k++) begin
                r_st[k] <= n_st[k];
            end
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[hdl/radar_measurement_jacobian.sv]
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Radar measurement Jacobian entries from a position/velocity state.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle in and out while the output
// is not stalled. Most of the pipeline depth is the bit-per-stage square
// root (DATA_WIDTH stages) followed by the bit-per-stage dividers
// (DATA_WIDTH+2 stages). A stalled output holds the whole pipeline; nothing
// is dropped or repeated. Zero range gives all-zero entries with zero_range
// set.
module radar_measurement_jacobian
    import rmj_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int NV   = 2 * DATA_WIDTH + 8;
    localparam int DLAT = DATA_WIDTH + 2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] mx, my, mvx, mvy;
        logic                  sx, sy, svx, svy, zero;
    } t_s1;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] mx, my;
        logic [SQ_W-1:0]       xx, yy, p1, p2;
        logic                  sx, sy, s1, s2, zero;
    } t_s2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] mx, my;
        logic [SQ_W-1:0]       sq, c;
        logic                  sx, sy, sc, zero;
    } t_side;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] mx, my, root;
        logic [SQ_W-1:0]       sq;
        logic [SQ_W-1:0]       sr_lo, sr_hi, yc_lo, yc_hi, xc_lo, xc_hi;
        logic                  sx, sy, sc, zero;
    } t_s4;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] mx, my, root;
        logic [SQ_W-1:0]       sq;
        logic [PROD_W-1:0]     sr, yc, xc;
        logic                  sx, sy, sc, zero;
    } t_s5;

    logic                  en;
    logic [NV-1:0]         r_vld;
    t_s1                   r_s1;
    t_s2                   r_s2;
    t_side                 r_s3;
    t_side                 r_dl [DATA_WIDTH];
    t_s4                   r_s4;
    t_s5                   r_s5;
    logic [DLAT-1:0]       r_zd;
    t_out_item             r_out;
    logic [DATA_WIDTH-1:0] root;
    logic [DATA_WIDTH-1:0] q_rx, q_ry, q_bx, q_by, q_tx, q_ty;

    logic [DATA_WIDTH+FRAC_BITS-1:0]   num_rx, num_ry;
    logic [DATA_WIDTH+2*FRAC_BITS-1:0] num_bx, num_by;
    logic [PROD_W+FRAC_BITS-1:0]       num_tx, num_ty;

    assign en         = ~r_vld[NV-1] | i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: sign and magnitude
            r_s1.mx   <= mag_of(i_in_data.pos_x);
            r_s1.my   <= mag_of(i_in_data.pos_y);
            r_s1.mvx  <= mag_of(i_in_data.vel_x);
            r_s1.mvy  <= mag_of(i_in_data.vel_y);
            r_s1.sx   <= i_in_data.pos_x[DATA_WIDTH-1];
            r_s1.sy   <= i_in_data.pos_y[DATA_WIDTH-1];
            r_s1.svx  <= i_in_data.vel_x[DATA_WIDTH-1];
            r_s1.svy  <= i_in_data.vel_y[DATA_WIDTH-1];
            r_s1.zero <= (i_in_data.pos_x == '0) && (i_in_data.pos_y == '0);

            // stage 2: squares and cross products
            r_s2.mx   <= r_s1.mx;
            r_s2.my   <= r_s1.my;
            r_s2.xx   <= SQ_W'(r_s1.mx) * SQ_W'(r_s1.mx);
            r_s2.yy   <= SQ_W'(r_s1.my) * SQ_W'(r_s1.my);
            r_s2.p1   <= SQ_W'(r_s1.mvx) * SQ_W'(r_s1.my);
            r_s2.p2   <= SQ_W'(r_s1.mvy) * SQ_W'(r_s1.mx);
            r_s2.sx   <= r_s1.sx;
            r_s2.sy   <= r_s1.sy;
            r_s2.s1   <= r_s1.svx ^ r_s1.sy;
            r_s2.s2   <= r_s1.svy ^ r_s1.sx;
            r_s2.zero <= r_s1.zero;

            // stage 3: range squared and signed cross term vx*y - vy*x
            r_s3.mx   <= r_s2.mx;
            r_s3.my   <= r_s2.my;
            r_s3.sq   <= r_s2.xx + r_s2.yy;
            r_s3.sx   <= r_s2.sx;
            r_s3.sy   <= r_s2.sy;
            r_s3.zero <= r_s2.zero;
            if (r_s2.s1 != r_s2.s2) begin
                r_s3.c  <= r_s2.p1 + r_s2.p2;
                r_s3.sc <= r_s2.s1;
            end else if (r_s2.p1 >= r_s2.p2) begin
                r_s3.c  <= r_s2.p1 - r_s2.p2;
                r_s3.sc <= r_s2.s1;
            end else begin
                r_s3.c  <= r_s2.p2 - r_s2.p1;
                r_s3.sc <= ~r_s2.s1;
            end

            // side data rides along with the square root
            r_dl[0] <= r_s3;
            for (int k = 1; k < DATA_WIDTH; k++) begin
                r_dl[k] <= r_dl[k-1];
            end

            // stage 4: 32x32 partial products of the wide products
            r_s4.mx    <= r_dl[DATA_WIDTH-1].mx;
            r_s4.my    <= r_dl[DATA_WIDTH-1].my;
            r_s4.root  <= root;
            r_s4.sq    <= r_dl[DATA_WIDTH-1].sq;
            r_s4.sx    <= r_dl[DATA_WIDTH-1].sx;
            r_s4.sy    <= r_dl[DATA_WIDTH-1].sy;
            r_s4.sc    <= r_dl[DATA_WIDTH-1].sc;
            r_s4.zero  <= r_dl[DATA_WIDTH-1].zero;
            r_s4.sr_lo <= SQ_W'(r_dl[DATA_WIDTH-1].sq[DATA_WIDTH-1:0]) * SQ_W'(root);
            r_s4.sr_hi <= SQ_W'(r_dl[DATA_WIDTH-1].sq[SQ_W-1:DATA_WIDTH]) * SQ_W'(root);
            r_s4.yc_lo <= SQ_W'(r_dl[DATA_WIDTH-1].c[DATA_WIDTH-1:0])
                          * SQ_W'(r_dl[DATA_WIDTH-1].my);
            r_s4.yc_hi <= SQ_W'(r_dl[DATA_WIDTH-1].c[SQ_W-1:DATA_WIDTH])
                          * SQ_W'(r_dl[DATA_WIDTH-1].my);
            r_s4.xc_lo <= SQ_W'(r_dl[DATA_WIDTH-1].c[DATA_WIDTH-1:0])
                          * SQ_W'(r_dl[DATA_WIDTH-1].mx);
            r_s4.xc_hi <= SQ_W'(r_dl[DATA_WIDTH-1].c[SQ_W-1:DATA_WIDTH])
                          * SQ_W'(r_dl[DATA_WIDTH-1].mx);

            // stage 5: combine partials
            r_s5.mx   <= r_s4.mx;
            r_s5.my   <= r_s4.my;
            r_s5.root <= r_s4.root;
            r_s5.sq   <= r_s4.sq;
            r_s5.sx   <= r_s4.sx;
            r_s5.sy   <= r_s4.sy;
            r_s5.sc   <= r_s4.sc;
            r_s5.zero <= r_s4.zero;
            r_s5.sr   <= (PROD_W'(r_s4.sr_hi) << DATA_WIDTH) + PROD_W'(r_s4.sr_lo);
            r_s5.yc   <= (PROD_W'(r_s4.yc_hi) << DATA_WIDTH) + PROD_W'(r_s4.yc_lo);
            r_s5.xc   <= (PROD_W'(r_s4.xc_hi) << DATA_WIDTH) + PROD_W'(r_s4.xc_lo);

            r_zd <= {r_zd[DLAT-2:0], r_s5.zero};

            if (r_zd[DLAT-1]) begin
                r_out.range_dx   <= '0;
                r_out.range_dy   <= '0;
                r_out.bearing_dx <= '0;
                r_out.bearing_dy <= '0;
                r_out.rate_dx    <= '0;
                r_out.rate_dy    <= '0;
                r_out.zero_range <= 1'b1;
            end else begin
                r_out.range_dx   <= q_rx;
                r_out.range_dy   <= q_ry;
                r_out.bearing_dx <= q_bx;
                r_out.bearing_dy <= q_by;
                r_out.rate_dx    <= q_tx;
                r_out.rate_dy    <= q_ty;
                r_out.zero_range <= 1'b0;
            end
        end
    end

    rmj_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_s3.sq),
        .o_root (root)
    );

    // numerators scaled by the fraction bits, twice over for the bearing terms
    assign num_rx = {r_s5.mx, {FRAC_BITS{1'b0}}};
    assign num_ry = {r_s5.my, {FRAC_BITS{1'b0}}};
    assign num_bx = {r_s5.my, {(2*FRAC_BITS){1'b0}}};
    assign num_by = {r_s5.mx, {(2*FRAC_BITS){1'b0}}};
    assign num_tx = {r_s5.yc, {FRAC_BITS{1'b0}}};
    assign num_ty = {r_s5.xc, {FRAC_BITS{1'b0}}};

    rmj_div u_div_rx (
        .i_clk (i_clk), .i_en (en),
        .i_hi  (PROD_W'(num_rx >> DATA_WIDTH)),
        .i_lo  (num_rx[DATA_WIDTH-1:0]),
        .i_den (PROD_W'(r_s5.root)),
        .i_neg (r_s5.sx),
        .o_q   (q_rx)
    );

    rmj_div u_div_ry (
        .i_clk (i_clk), .i_en (en),
        .i_hi  (PROD_W'(num_ry >> DATA_WIDTH)),
        .i_lo  (num_ry[DATA_WIDTH-1:0]),
        .i_den (PROD_W'(r_s5.root)),
        .i_neg (r_s5.sy),
        .o_q   (q_ry)
    );

    rmj_div u_div_bx (
        .i_clk (i_clk), .i_en (en),
        .i_hi  (PROD_W'(num_bx >> DATA_WIDTH)),
        .i_lo  (num_bx[DATA_WIDTH-1:0]),
        .i_den (PROD_W'(r_s5.sq)),
        .i_neg (~r_s5.sy),
        .o_q   (q_bx)
    );

    rmj_div u_div_by (
        .i_clk (i_clk), .i_en (en),
        .i_hi  (PROD_W'(num_by >> DATA_WIDTH)),
        .i_lo  (num_by[DATA_WIDTH-1:0]),
        .i_den (PROD_W'(r_s5.sq)),
        .i_neg (r_s5.sx),
        .o_q   (q_by)
    );

    rmj_div u_div_tx (
        .i_clk (i_clk), .i_en (en),
        .i_hi  (PROD_W'(num_tx >> DATA_WIDTH)),
        .i_lo  (num_tx[DATA_WIDTH-1:0]),
        .i_den (r_s5.sr),
        .i_neg (r_s5.sy ^ r_s5.sc),
        .o_q   (q_tx)
    );

    rmj_div u_div_ty (
        .i_clk (i_clk), .i_en (en),
        .i_hi  (PROD_W'(num_ty >> DATA_WIDTH)),
        .i_lo  (num_ty[DATA_WIDTH-1:0]),
        .i_den (r_s5.sr),
        .i_neg (~(r_s5.sx ^ r_s5.sc)),
        .o_q   (q_ty)
    );

    assign o_out_valid = r_vld[NV-1];
    assign o_out_data  = r_out;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Radar measurement Jacobian check: a short directed table, then random
// state vectors. Each result is compared against a typed value or an exact
// wide-integer Jacobian calculation, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
    import rmj_pkg::*;

    localparam int N_RANDOM   = 1300;
    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN_CYC  = 2 * DATA_WIDTH + 40;
    localparam int WIDE       = 192;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item result;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    t_out_item jac_queue[$];
    int        err_cnt;
    int        quiet_cycles;
    bit        steady;

    radar_measurement_jacobian u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // truncated quotient, saturated to the signed data range
    function automatic logic [DATA_WIDTH-1:0] sat_quot(
        input logic signed [WIDE-1:0] num, input logic [WIDE-1:0] den);
        logic          neg;
        logic [WIDE-1:0] mag, q, lim;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = mag / den;
        lim = (WIDE'(1) << (DATA_WIDTH - 1)) - (neg ? 0 : 1);
        if (q > lim) q = lim;
        if (neg) q = -q;
        return q[DATA_WIDTH-1:0];
    endfunction

    function automatic t_out_item jacobian(input t_in_item st);
        logic signed [WIDE-1:0] x, y, vx, vy, c;
        logic [WIDE-1:0]        s, r, t;
        t_out_item              j;
        x  = WIDE'(st.pos_x);
        y  = WIDE'(st.pos_y);
        vx = WIDE'(st.vel_x);
        vy = WIDE'(st.vel_y);
        j = '0;
        if (x == 0 && y == 0) begin
            j.zero_range = 1'b1;
            return j;
        end
        s = x * x + y * y;
        r = '0;
        for (int i = 33; i >= 0; i--) begin
            t = r | (WIDE'(1) << i);
            if (t * t <= s) r = t;
        end
        c = vx * y - vy * x;
        j.range_dx   = sat_quot(x <<< FRAC_BITS, r);
        j.range_dy   = sat_quot(y <<< FRAC_BITS, r);
        j.bearing_dx = sat_quot(-(y <<< (2 * FRAC_BITS)), s);
        j.bearing_dy = sat_quot(x <<< (2 * FRAC_BITS), s);
        j.rate_dx    = sat_quot((y * c) <<< FRAC_BITS, s * r);
        j.rate_dy    = sat_quot(-((x * c) <<< FRAC_BITS), s * r);
        return j;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_coord();
        case ($urandom_range(6))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return $urandom_range(0, 2) - 1;
            3: return 0;
            4: return DATA_WIDTH'($signed($urandom_range(0, 2 ** 12)) - 2 ** 11);
            default: return DATA_WIDTH'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
        endcase
    endfunction

    // directed rows; typed results where they follow directly
    function automatic t_row row(input logic [DATA_WIDTH-1:0] px, py, vx, vy);
        t_row rw;
        rw.stim  = '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy};
        rw.typed = 1'b0;
        rw.result = '0;
        return rw;
    endfunction

    t_row table_rows[$];

    task automatic send(input t_in_item st, input bit typed, input t_out_item res);
        while (!steady && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= st;
        do @(posedge i_clk); while (!o_in_ready);
        jac_queue.push_back(typed ? res : jacobian(st));
    endtask

    initial begin
        t_row     rw;
        t_in_item st;
        err_cnt    = 0;
        steady     = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero range, velocity ignored
        rw = row(0, 0, 32'h7fff_ffff, 32'h8000_0000);
        rw.typed = 1'b1; rw.result = '0; rw.result.zero_range = 1'b1;
        table_rows.push_back(rw);
        rw = row(0, 0, 0, 0);
        rw.typed = 1'b1; rw.result = '0; rw.result.zero_range = 1'b1;
        table_rows.push_back(rw);
        // unit x position: rate_dy reduces to vel_y
        rw = row(32'h0001_0000, 0, 32'h0005_0000, 32'h0003_0000);
        rw.typed = 1'b1;
        rw.result = '{range_dx: 32'h0001_0000, range_dy: 0, bearing_dx: 0,
                      bearing_dy: 32'h0001_0000, rate_dx: 0,
                      rate_dy: 32'h0003_0000, zero_range: 1'b0};
        table_rows.push_back(rw);
        table_rows.push_back(row(1, 0, 0, 0));
        table_rows.push_back(row(0, 32'hffff_ffff, 32'h7fff_ffff, 1));
        table_rows.push_back(row(1, 1, 32'h7fff_ffff, 32'h8000_0000));
        table_rows.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        table_rows.push_back(row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        table_rows.push_back(row(32'h8000_0000, 0, 32'hffff_ffff, 32'hffff_ffff));
        table_rows.push_back(row(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff));
        table_rows.push_back(row(32'hfffe_0000, 32'h0003_0000, 32'h0001_8000, 32'hffff_0000));
        table_rows.push_back(row(32'h0000_0100, 32'hffff_ff00, 32'h7fff_ffff, 32'h7fff_ffff));
        table_rows.push_back(row(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555));

        foreach (table_rows[k])
            send(table_rows[k].stim, table_rows[k].typed, table_rows[k].result);

        for (int n = 0; n < N_RANDOM; n++) begin
            steady = (n >= 500 && n < 800);
            st.pos_x = rand_coord();
            st.pos_y = rand_coord();
            st.vel_x = rand_coord();
            st.vel_y = rand_coord();
            send(st, 1'b0, '0);
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        while (jac_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= steady || ($urandom_range(99) >= 14);
    end

    initial i_out_ready = 1'b0;

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        logic [$bits(t_out_item)-1:0] wv, gv;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (jac_queue.size() == 0) begin
                $display("%0t: unexpected transaction, got %h", $time, o_out_data);
                err_cnt++;
            end else begin
                want = jac_queue.pop_front();
                wv = want;
                gv = o_out_data;
                for (int k = 0; k < 6; k++)
                    if (gv[192 - 32 * k -: 32] !== wv[192 - 32 * k -: 32]) begin
                        $display("%0t: field %0d mismatch, expected %h, actual %h",
                                 $time, k, wv[192 - 32 * k -: 32], gv[192 - 32 * k -: 32]);
                        err_cnt++;
                    end
                if (gv[0] !== wv[0]) begin
                    $display("%0t: zero_range mismatch, expected %b, actual %b",
                             $time, wv[0], gv[0]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

[radar_measurement_jacobian.f]
hdl/rmj_pkg.sv
hdl/rmj_isqrt.sv
hdl/rmj_div.sv
hdl/radar_measurement_jacobian.sv
dv/testbench.sv
